/* design/huffman_tree_walk_decoder_core_defines.svh */
// Assertion macros for the tree-walk decoder.
// Both expect clk and rst in the scope where they are used.
`ifndef HUFFMAN_TREE_WALK_DECODER_CORE_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication
`define HTWD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define HTWD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HTWD_ASSERT_IMP(name, ante, cons, msg)
`define HTWD_ASSERT_NXT(name, ante, cons, msg)

`endif

`endif

/* design/htwd_pkg.sv */
package htwd_pkg;

  // Node table geometry
  localparam int NODE_COUNT = 512;
  localparam int ADDR_W     = $clog2(NODE_COUNT);
  localparam int IDX_W      = 9;
  localparam int SYM_W      = 8;

  localparam logic [SYM_W-1:0] END_SYMBOL_RESET = 8'h03;

  // One table entry: leaf flag, symbol, left child, right child
  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  // Register indexes (word address bit 2)
  localparam logic REG_ROOT = 1'b0;
  localparam logic REG_END  = 1'b1;

  // Sequencer steps
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_TEST = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // Jump conditions
  localparam logic [1:0] COND_NONE = 2'd0;  // always tgt_t
  localparam logic [1:0] COND_GO   = 2'd1;  // decode accepted ? tgt_t : tgt_f
  localparam logic [1:0] COND_TEST = 2'd2;  // finish ? tgt_done : leaf ? tgt_t : tgt_f

  typedef struct packed {
    logic       busy;
    logic       walk;   // pick child of fetched entry, read it
    logic       test;   // examine fetched child
    logic       flush;  // emit held result as last of byte
    logic [1:0] cond;
    logic [1:0] tgt_done;
    logic [1:0] tgt_t;
    logic [1:0] tgt_f;
  } ucode_t;

  // Control store
  function automatic ucode_t ucode_rom(input logic [1:0] step);
    ucode_t w;
    w = '0;
    case (step)
      ST_IDLE: begin
        w.cond = COND_GO;  w.tgt_t = ST_WALK; w.tgt_f = ST_IDLE;
      end
      ST_WALK: begin
        w.busy = 1'b1; w.walk = 1'b1;
        w.cond = COND_NONE; w.tgt_t = ST_TEST;
      end
      ST_TEST: begin
        w.busy = 1'b1; w.test = 1'b1;
        w.cond = COND_TEST; w.tgt_done = ST_DONE;
        w.tgt_t = ST_WALK; w.tgt_f = ST_TEST;
      end
      ST_DONE: begin
        w.busy = 1'b1; w.flush = 1'b1;
        w.cond = COND_NONE; w.tgt_t = ST_IDLE;
      end
      default: begin
        w.cond = COND_NONE; w.tgt_t = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  // Node index to table address
  function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
    logic [IDX_W+ADDR_W-1:0] wide;
    wide = {{ADDR_W{1'b0}}, idx};
    return wide[ADDR_W-1:0];
  endfunction

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return 32'(idx) < 32'(NODE_COUNT);
  endfunction

endpackage

/* design/htwd_ram.sv */
module htwd_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q <= mem[raddr];
  end

endmodule

/* design/huffman_tree_walk_decoder_core.sv */
// Huffman tree-walk decoder.
// Command channel: an item is taken when start is high and busy is low.
//   mode 0 loads one node into the node table and clears the stop flag;
//   mode 1 decodes one compressed byte, bit 0 first.
// Result channel: one symbol per cycle while result_valid is high; the
//   receiver cannot stall, so every strobe must be taken. last marks the
//   final symbol of a byte, end_reached the end symbol (which stops decoding
//   until the next load).
// Sequence: loads, and bytes dropped while stopped, are taken without raising busy.
//   A decoded byte takes an accept step, a fetch, 8 bit steps, an extra fetch per
//   symbol found before the last bit and a flush step; busy stays high until the flush.
//   The end symbol cuts the byte short, going straight to the flush step.
//   The rate is set by the node table's single registered read port: each
//   bit step waits on one table read, and a return to the root costs one more.
// Results trail the leaf that produced them by one symbol or the flush cycle.
// Reset clears the walk position, stop flag and registers (root 0, end 3);
//   the node table holds garbage until loaded.
// Config: APB, root_node at 0x0, end_symbol at 0x4; write while idle only.
module huffman_tree_walk_decoder_core
  import htwd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // config port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // request channel
  input  logic             start,
  output logic             busy,
  input  logic             mode,
  input  logic [7:0]       compressed_byte,
  input  logic [IDX_W-1:0] node_index,
  input  logic             node_is_leaf,
  input  logic [SYM_W-1:0] node_symbol,
  input  logic [IDX_W-1:0] left_child,
  input  logic [IDX_W-1:0] right_child,
  // result channel
  output logic             result_valid,
  output logic [SYM_W-1:0] symbol,
  output logic             last,
  output logic             end_reached
);

  `include "huffman_tree_walk_decoder_core_defines.svh"

  // Registers
  logic [IDX_W-1:0] root_node;
  logic [SYM_W-1:0] end_symbol;
  logic [1:0]       step;
  logic [1:0]       step_next;
  logic [IDX_W-1:0] current_node;
  logic             inside_code;
  logic             stopped;
  logic [7:0]       byte_sr;
  logic [2:0]       bit_cnt;
  logic [IDX_W-1:0] child_idx;
  logic             rd_oor;
  logic             pend_valid;
  logic [SYM_W-1:0] pend_sym;
  logic             pend_end;

  ucode_t           cw;
  logic             accept;
  logic             go;
  logic             cfg_wr;
  logic [NODE_W-1:0] ram_q;
  node_t            q_node;
  node_t            wr_node;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] walk_child;
  logic [IDX_W-1:0] next_child;
  logic             leaf;
  logic             is_end;
  logic             finish;
  logic             ram_we;

  // Config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_ROOT: prdata = {{(32-IDX_W){1'b0}}, root_node};
      REG_END:  prdata = {{(32-SYM_W){1'b0}}, end_symbol};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_node  <= '0;
      end_symbol <= END_SYMBOL_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ROOT: root_node  <= pwdata[IDX_W-1:0];
        REG_END:  end_symbol <= pwdata[SYM_W-1:0];
        default:  ;
      endcase
    end
  end

  // Control word and handshake
  assign cw     = ucode_rom(step);
  assign busy   = cw.busy;
  assign accept = start && !busy;
  assign go     = accept && mode && !stopped;

  // Fetched entry; out-of-range indexes read as an all-zero node
  assign q_node     = rd_oor ? node_t'('0) : node_t'(ram_q);
  assign walk_child = byte_sr[0] ? q_node.right : q_node.left;
  assign next_child = byte_sr[1] ? q_node.right : q_node.left;
  assign leaf       = q_node.leaf;
  assign is_end     = (q_node.symbol == end_symbol);
  assign finish     = (bit_cnt == 3'd7) || (leaf && is_end);

  // Read address select
  always_comb begin
    rd_idx = root_node;
    if (cw.walk) begin
      rd_idx = walk_child;
    end else if (cw.test) begin
      rd_idx = leaf ? root_node : next_child;
    end else if (go) begin
      rd_idx = inside_code ? current_node : root_node;
    end
  end

  // Node table
  assign wr_node = '{leaf: node_is_leaf, symbol: node_symbol,
                     left: left_child, right: right_child};
  assign ram_we  = accept && !mode && in_range(node_index);

  htwd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (to_addr(node_index)),
    .wdata (wr_node),
    .raddr (to_addr(rd_idx)),
    .q     (ram_q)
  );

  always_ff @(posedge clk) begin
    rd_oor <= !in_range(rd_idx);
  end

  // Sequencer jump
  always_comb begin
    case (cw.cond)
      COND_NONE: step_next = cw.tgt_t;
      COND_GO:   step_next = go ? cw.tgt_t : cw.tgt_f;
      COND_TEST: step_next = finish ? cw.tgt_done : (leaf ? cw.tgt_t : cw.tgt_f);
      default:   step_next = ST_IDLE;
    endcase
  end

  // Walk state and results
  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= ST_IDLE;
      current_node <= '0;
      inside_code  <= 1'b0;
      stopped      <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      step         <= step_next;
      // held symbol leaves on the next leaf or on the flush
      result_valid <= pend_valid && ((cw.test && leaf) || cw.flush);

      if (accept && !mode) begin
        stopped <= 1'b0;
      end

      if (go) begin
        byte_sr <= compressed_byte;
        bit_cnt <= '0;
      end

      if (cw.walk) begin
        child_idx <= walk_child;
      end

      if (cw.test) begin
        if (!finish) begin
          byte_sr <= byte_sr >> 1;
          bit_cnt <= bit_cnt + 3'd1;
        end
        if (leaf) begin
          // symbol found: release the one held back, hold this one
          if (pend_valid) begin
            symbol       <= pend_sym;
            last         <= 1'b0;
            end_reached  <= pend_end;
          end
          pend_valid   <= 1'b1;
          pend_sym     <= q_node.symbol;
          pend_end     <= is_end;
          inside_code  <= 1'b0;
          current_node <= '0;
          if (is_end) begin
            stopped <= 1'b1;
          end
        end else begin
          inside_code  <= 1'b1;
          current_node <= child_idx;
          child_idx    <= next_child;
        end
      end

      // end of byte: held symbol is the last one
      if (cw.flush && pend_valid) begin
        symbol       <= pend_sym;
        last         <= 1'b1;
        end_reached  <= pend_end;
        pend_valid   <= 1'b0;
      end
    end
  end

  // Checks
  `HTWD_ASSERT_IMP(a_res_src, result_valid, $past(step == ST_TEST || step == ST_DONE), "result outside walk")
  `HTWD_ASSERT_IMP(a_last_src, result_valid && last, $past(step == ST_DONE), "last not from flush")
  `HTWD_ASSERT_IMP(a_idle_empty, !busy, !pend_valid, "held result left after byte")
  `HTWD_ASSERT_IMP(a_stop_src, $rose(stopped), $past(step == ST_TEST), "stop set outside bit test")
  `HTWD_ASSERT_NXT(a_load_clr, accept && !mode, !stopped, "load did not clear stop")

endmodule
